>>> src/frs_pkg.sv
// Package for the fitness roulette selector: widths, codes and the types
// shared by the top level and the iterative divider. No dependencies.
package frs_pkg;

  localparam int MAX_POP = 256;
  localparam int IDX_W   = $clog2(MAX_POP);
  localparam int SIZE_W  = 9;
  localparam int FIT_W   = 32;
  localparam int TOT_W   = 40;
  localparam int DIV_CNT_W = $clog2(TOT_W);

  localparam logic [SIZE_W-1:0] POP_RESET = SIZE_W'(16);
  localparam logic [SIZE_W-1:0] POP_MAX   = SIZE_W'(MAX_POP);

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STATS  = 2'd1,
    ACT_SELECT = 2'd2,
    ACT_NONE   = 2'd3
  } frs_action_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_NOSEL = 2'd1,
    STATUS_RANGE = 2'd2
  } frs_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV
  } frs_state_t;

  typedef struct packed {
    logic              start;
    logic [TOT_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } frs_div_req_t;

  typedef struct packed {
    logic             done;
    logic [TOT_W-1:0] quotient;
  } frs_div_rsp_t;

endpackage

>>> src/frs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module frs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/frs_div.sv
// Restoring divider, one quotient bit per cycle, for the statistics average.
// Depends on frs_pkg.
module frs_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  frs_pkg::frs_div_req_t req,
  output frs_pkg::frs_div_rsp_t rsp
);
  import frs_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TOT_W-1:0]     quo_r, quo_nxt;
  logic [SIZE_W-1:0]    rem_r, rem_nxt;
  logic [SIZE_W-1:0]    div_r, div_nxt;
  logic [SIZE_W:0]      rem_sh;
  logic [SIZE_W:0]      diff;
  logic                 ge;

  assign rem_sh = {rem_r, quo_r[TOT_W-1]};
  assign ge     = rem_sh >= {1'b0, div_r};
  assign diff   = rem_sh - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[TOT_W-2:0], ge};
      rem_nxt = ge ? diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(TOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> src/fitness_roulette_selector.sv
// Fitness roulette selector top level: fitness table, statistics scan and
// roulette select. Depends on frs_pkg, frs_ram and frs_div.
//
// A transaction is accepted when start is high and busy is low. Every
// transaction gives one result, shown for exactly one cycle with out_strobe
// high; the receiver cannot stall, so a result is never held back.
// A load writes one table entry if its index is below the size in use,
// else it reports STATUS_RANGE; it reports in the next cycle and busy stays
// low, so another transaction can follow at once.
// A statistics transaction reads the entries in use one per cycle from the
// registered read port, then runs the restoring divider for the average.
// A select transaction walks the running sum one entry per cycle and stops
// at the first qualifying entry.
// The statistics outputs always show the latched statistics registers.
// The population size is written on the cfg channel while busy is low.
// Reset clears the statistics registers and sets the size to 16; the table
// holds no defined contents until its entries are loaded.
module fitness_roulette_selector (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_action,
  input  logic [7:0]                  in_entry_index,
  input  logic [frs_pkg::FIT_W-1:0]   in_fitness_value,
  input  logic [frs_pkg::TOT_W-1:0]   in_random_value,
  output logic                        out_strobe,
  output logic [1:0]                  out_status,
  output logic [7:0]                  out_selected_index,
  output logic [frs_pkg::TOT_W-1:0]   out_fitness_total,
  output logic [frs_pkg::FIT_W-1:0]   out_best_value,
  output logic [frs_pkg::FIT_W-1:0]   out_worst_value,
  output logic [7:0]                  out_best_entry,
  output logic [frs_pkg::FIT_W-1:0]   out_average_value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [frs_pkg::SIZE_W-1:0]  cfg_population_size
);
  import frs_pkg::*;

  frs_state_t        state_r, state_nxt;
  frs_action_t       action_r, action_nxt;
  frs_action_t       in_act;
  logic [SIZE_W-1:0] pop_r, pop_nxt;
  logic [SIZE_W-1:0] n_r, n_nxt;
  logic [SIZE_W-1:0] n_use;
  logic [TOT_W-1:0]  draw_r, draw_nxt;
  logic [SIZE_W-1:0] issue_cnt_r, issue_cnt_nxt;
  logic              data_vld_r;
  logic [IDX_W-1:0]  data_idx_r;
  logic              data_last_r;
  logic [TOT_W-1:0]  sum_r, sum_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [FIT_W-1:0]  best_r, best_nxt;
  logic [FIT_W-1:0]  worst_r, worst_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [FIT_W-1:0]  avg_r, avg_nxt;
  logic              strobe_r, strobe_nxt;
  frs_status_t       status_r, status_nxt;
  logic [IDX_W-1:0]  sel_r, sel_nxt;
  logic              accept;
  logic              rd_en;
  logic              wr_en;
  logic [FIT_W-1:0]  rd_data;
  logic [TOT_W:0]    total_add;
  logic [TOT_W:0]    pick_sum;
  frs_div_req_t      div_req;
  frs_div_rsp_t      div_rsp;

  assign in_act = frs_action_t'(in_action);
  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    n_use = pop_r;
    if (pop_r == '0) begin
      n_use = SIZE_W'(1);
    end else if (pop_r > POP_MAX) begin
      n_use = POP_MAX;
    end
  end

  assign wr_en = accept && (in_act == ACT_LOAD) && ({1'b0, in_entry_index} < n_use);
  assign rd_en = (state_r == ST_SCAN) && (issue_cnt_r < n_r);

  frs_ram #(
    .WIDTH(FIT_W),
    .DEPTH(MAX_POP)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(in_entry_index[IDX_W-1:0]),
    .wdata(in_fitness_value),
    .re   (rd_en),
    .raddr(issue_cnt_r[IDX_W-1:0]),
    .rdata(rd_data)
  );

  assign total_add = {1'b0, total_r} + {{(TOT_W - FIT_W + 1){1'b0}}, rd_data};
  assign pick_sum  = {1'b0, sum_r} + {{(TOT_W - FIT_W + 1){1'b0}}, rd_data};

  frs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    pop_nxt       = pop_r;
    n_nxt         = n_r;
    draw_nxt      = draw_r;
    issue_cnt_nxt = issue_cnt_r;
    sum_nxt       = sum_r;
    total_nxt     = total_r;
    best_nxt      = best_r;
    worst_nxt     = worst_r;
    best_idx_nxt  = best_idx_r;
    avg_nxt       = avg_r;
    strobe_nxt    = 1'b0;
    status_nxt    = status_r;
    sel_nxt       = sel_r;
    div_req.start    = 1'b0;
    div_req.dividend = total_r;
    div_req.divisor  = n_r;

    if (cfg_valid && cfg_ready) begin
      pop_nxt = cfg_population_size;
    end
    if (rd_en) begin
      issue_cnt_nxt = issue_cnt_r + SIZE_W'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          action_nxt    = in_act;
          n_nxt         = n_use;
          draw_nxt      = in_random_value;
          issue_cnt_nxt = '0;
          sum_nxt       = '0;
          sel_nxt       = '0;
          status_nxt    = STATUS_OK;
          case (in_act)
            ACT_LOAD: begin
              strobe_nxt = 1'b1;
              if (!wr_en) begin
                status_nxt = STATUS_RANGE;
              end
            end
            ACT_STATS: begin
              total_nxt = '0;
              best_nxt  = '0;
              worst_nxt = '1;
              state_nxt = ST_SCAN;
            end
            ACT_SELECT: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (data_vld_r) begin
          if (action_r == ACT_STATS) begin
            total_nxt = total_add[TOT_W] ? '1 : total_add[TOT_W-1:0];
            if (rd_data > best_r) begin
              best_nxt     = rd_data;
              best_idx_nxt = data_idx_r;
            end
            if (rd_data < worst_r) begin
              worst_nxt = rd_data;
            end
            if (data_last_r) begin
              div_req.start    = 1'b1;
              div_req.dividend = total_nxt;
              state_nxt        = ST_DIV;
            end
          end else begin
            if (pick_sum > {1'b0, draw_r}) begin
              strobe_nxt = 1'b1;
              sel_nxt    = data_idx_r;
              state_nxt  = ST_IDLE;
            end else begin
              sum_nxt = pick_sum[TOT_W-1:0];
              if (data_last_r) begin
                strobe_nxt = 1'b1;
                status_nxt = STATUS_NOSEL;
                state_nxt  = ST_IDLE;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          avg_nxt    = (div_rsp.quotient[TOT_W-1:FIT_W] != '0) ? '1
                                                           : div_rsp.quotient[FIT_W-1:0];
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pop_r      <= POP_RESET;
      data_vld_r <= 1'b0;
      strobe_r   <= 1'b0;
      total_r    <= '0;
      best_r     <= '0;
      worst_r    <= '0;
      best_idx_r <= '0;
      avg_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      pop_r      <= pop_nxt;
      data_vld_r <= rd_en;
      strobe_r   <= strobe_nxt;
      total_r    <= total_nxt;
      best_r     <= best_nxt;
      worst_r    <= worst_nxt;
      best_idx_r <= best_idx_nxt;
      avg_r      <= avg_nxt;
    end
    action_r    <= action_nxt;
    n_r         <= n_nxt;
    draw_r      <= draw_nxt;
    issue_cnt_r <= issue_cnt_nxt;
    data_idx_r  <= issue_cnt_r[IDX_W-1:0];
    data_last_r <= (issue_cnt_r == (n_r - SIZE_W'(1)));
    sum_r       <= sum_nxt;
    status_r    <= status_nxt;
    sel_r       <= sel_nxt;
  end

  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_selected_index = sel_r;
  assign out_fitness_total  = total_r;
  assign out_best_value     = best_r;
  assign out_worst_value    = worst_r;
  assign out_best_entry     = best_idx_r;
  assign out_average_value  = avg_r;

  a_strobe_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy) || $past(start))
    else $error("result strobe without a transaction in progress");

  a_nosel_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STATUS_NOSEL) |-> out_selected_index == '0)
    else $error("failed select reports a nonzero index");

  a_best_not_below_worst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_best_value >= out_worst_value)
    else $error("best value below worst value at a result");

  a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> !$past(state_r == ST_DIV && !div_rsp.done) || !busy)
    else $error("configuration write accepted during a scan");

endmodule
